>>> rtl/rda_pkg.sv
// ----------------------------------------------------------------------------
// Ring descriptor allocator package
// Function codes, status codes and the command record passed between the
// front and back halves of the allocator.
// ----------------------------------------------------------------------------
package rda_pkg;

   localparam int IDX_W = 8;
   localparam int CNT_W = 9;
   localparam int STATUS_W = 2;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_DOUBLE = 2'd3;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE = 2'd1,
      OP_RANGE = 2'd2
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
      logic [IDX_W-1:0] head;
   } cmd_type;

endpackage

>>> rtl/rda_if.sv
// ----------------------------------------------------------------------------
// Ring descriptor allocator channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rda_req_if import rda_pkg::*; ();
   logic valid;
   logic ready;
   logic func;
   logic [IDX_W-1:0] head_index;

   modport source (output valid, output func, output head_index, input ready);
   modport sink (input valid, input func, input head_index, output ready);
endinterface

interface rda_rsp_if import rda_pkg::*; ();
   logic valid;
   logic ready;
   logic [STATUS_W-1:0] status_code;
   logic [IDX_W-1:0] first_index;
   logic [IDX_W-1:0] second_index;
   logic [IDX_W-1:0] third_index;
   logic [CNT_W-1:0] freed_count;

   modport source (output valid, output status_code, output first_index,
                   output second_index, output third_index, output freed_count,
                   input ready);
   modport sink (input valid, input status_code, input first_index,
                 input second_index, input third_index, input freed_count,
                 output ready);
endinterface

>>> rtl/ring_descriptor_allocator.sv
// ----------------------------------------------------------------------------
// Ring descriptor allocator
// Free map and chain links for a table of ring descriptors: allocates
// three-entry chains and frees chains by walking their links.
//
//   channel    dir   beat contents
//   req_chan   in    func, head_index
//   rsp_chan   out   status_code, first_index, second_index, third_index,
//                    freed_count
//
// Allocate: one lowest-free search per chain entry, then the last link
//   write; a search that finds nothing free answers no space. Free: walks
//   the chain from its head; the link memory read port gives one entry per
//   cycle. A head out of range gets a range status. Two requests queue
//   ahead of the back end; the response register holds a beat until taken
//   and the back end starts no command while it is full and not taken.
// Reset is synchronous; every entry is free after it, no clearing pass.
// ----------------------------------------------------------------------------
module ring_descriptor_allocator import rda_pkg::*; #(
   parameter int DESC_COUNT = 8
) (
   input logic clock,
   input logic reset,
   rda_req_if.sink req_chan,
   rda_rsp_if.source rsp_chan
);

   logic cmd_valid;
   cmd_type cmd;
   logic cmd_pop;

   rda_front #(
      .DESC_COUNT(DESC_COUNT)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req(req_chan),
      .cmd_valid(cmd_valid),
      .cmd(cmd),
      .cmd_pop(cmd_pop)
   );

   rda_back #(
      .DESC_COUNT(DESC_COUNT)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .cmd_valid(cmd_valid),
      .cmd(cmd),
      .cmd_pop(cmd_pop),
      .rsp(rsp_chan)
   );

endmodule

>>> rtl/rda_front.sv
// ----------------------------------------------------------------------------
// Ring descriptor allocator front end
// Accepts request beats, classifies them into commands and holds them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module rda_front import rda_pkg::*; #(
   parameter int DESC_COUNT = 8
) (
   input logic clock,
   input logic reset,
   rda_req_if.sink req,
   output logic cmd_valid,
   output cmd_type cmd,
   input logic cmd_pop
);

   localparam int QUEUE_DEPTH = 2;

   cmd_type slot_ff [QUEUE_DEPTH];
   logic [1:0] count_ff, count_in;
   logic wr_ptr_ff, rd_ptr_ff;
   logic push;
   cmd_type new_cmd;

   assign req.ready = count_ff != 2'(QUEUE_DEPTH);
   assign push = req.valid && req.ready;
   assign cmd_valid = count_ff != 2'd0;
   assign cmd = slot_ff[rd_ptr_ff];

   // classify: heads past the table end never reach the walk
   always_comb begin
      new_cmd.head = req.head_index;
      if (req.func == FUNC_ALLOC) begin
         new_cmd.op = OP_ALLOC;
      end else if (9'(req.head_index) >= 9'(DESC_COUNT)) begin
         new_cmd.op = OP_RANGE;
      end else begin
         new_cmd.op = OP_FREE;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (push && !cmd_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && cmd_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (cmd_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

>>> rtl/rda_back.sv
// ----------------------------------------------------------------------------
// Ring descriptor allocator back end
// Owns the free map and the link memory, runs allocate and free commands and
// holds the response register.
// ----------------------------------------------------------------------------
module rda_back import rda_pkg::*; #(
   parameter int DESC_COUNT = 8
) (
   input logic clock,
   input logic reset,
   input logic cmd_valid,
   input cmd_type cmd,
   output logic cmd_pop,
   rda_rsp_if.source rsp
);

   localparam int IW = $clog2(DESC_COUNT);

   typedef struct packed {
      logic has_next;
      logic [IW-1:0] link;
   } link_word_type;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_BAD = 7'b0000010,
      S_ALLOC0 = 7'b0000100,
      S_ALLOC1 = 7'b0001000,
      S_ALLOC2 = 7'b0010000,
      S_LINK = 7'b0100000,
      S_WALK = 7'b1000000
   } be_state_type;

   be_state_type state_ff, state_in;
   logic [DESC_COUNT-1:0] free_map_ff, free_map_in;
   logic [DESC_COUNT-1:0] avail_ff, avail_in;
   logic [IW-1:0] pick0_ff, pick0_in, pick1_ff, pick1_in, pick2_ff, pick2_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic walk_first_ff, walk_first_in;
   logic [CNT_W-1:0] count_ff, count_in;

   link_word_type link_mem [DESC_COUNT];
   link_word_type rd_ff;
   logic mem_we;
   logic [IW-1:0] mem_waddr, mem_raddr;
   link_word_type mem_wdata;

   logic rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, res_status;
   logic [IDX_W-1:0] rsp_first_ff, rsp_second_ff, rsp_third_ff;
   logic [IDX_W-1:0] res_first, res_second, res_third;
   logic [CNT_W-1:0] rsp_count_ff, res_count;
   logic rsp_load;
   logic out_free;

   logic [DESC_COUNT-1:0] scan, low_vec;
   logic scan_any;
   logic [IW-1:0] pick_idx;
   logic [IDX_W-1:0] cur;
   logic [IW-1:0] cur_idx;
   logic in_range;

   assign rsp.valid = rsp_valid_ff;
   assign rsp.status_code = rsp_status_ff;
   assign rsp.first_index = rsp_first_ff;
   assign rsp.second_index = rsp_second_ff;
   assign rsp.third_index = rsp_third_ff;
   assign rsp.freed_count = rsp_count_ff;

   assign out_free = !rsp_valid_ff || rsp.ready;

   // lowest free entry of the scan mask
   assign scan = (state_ff == S_ALLOC0) ? free_map_ff : avail_ff;
   assign low_vec = scan & (~scan + DESC_COUNT'(1));
   assign scan_any = |scan;

   always_comb begin
      pick_idx = '0;
      for (int i = 0; i < DESC_COUNT; i++) begin
         if (low_vec[i]) begin
            pick_idx = IW'(i);
         end
      end
   end

   // walk address: head on the first step, else the link just read
   assign cur = walk_first_ff ? head_ff : IDX_W'(rd_ff.link);
   assign cur_idx = cur[IW-1:0];
   assign in_range = 9'(cur) < 9'(DESC_COUNT);
   assign mem_raddr = cur_idx;

   always_comb begin
      state_in = state_ff;
      free_map_in = free_map_ff;
      avail_in = avail_ff;
      pick0_in = pick0_ff;
      pick1_in = pick1_ff;
      pick2_in = pick2_ff;
      head_in = head_ff;
      walk_first_in = walk_first_ff;
      count_in = count_ff;
      mem_we = 1'b0;
      mem_waddr = '0;
      mem_wdata = '0;
      cmd_pop = 1'b0;
      rsp_load = 1'b0;
      res_status = STATUS_OK;
      res_first = '0;
      res_second = '0;
      res_third = '0;
      res_count = '0;

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop = 1'b1;
               head_in = cmd.head;
               walk_first_in = 1'b1;
               count_in = '0;
               case (cmd.op)
                  OP_ALLOC: state_in = S_ALLOC0;
                  OP_FREE: state_in = S_WALK;
                  default: state_in = S_BAD;
               endcase
            end
         end
         S_BAD: begin
            rsp_load = 1'b1;
            res_status = STATUS_RANGE;
            state_in = S_IDLE;
         end
         S_ALLOC0: begin
            if (!scan_any) begin
               rsp_load = 1'b1;
               res_status = STATUS_NO_SPACE;
               state_in = S_IDLE;
            end else begin
               pick0_in = pick_idx;
               avail_in = scan & ~low_vec;
               state_in = S_ALLOC1;
            end
         end
         S_ALLOC1: begin
            if (!scan_any) begin
               rsp_load = 1'b1;
               res_status = STATUS_NO_SPACE;
               state_in = S_IDLE;
            end else begin
               pick1_in = pick_idx;
               avail_in = scan & ~low_vec;
               mem_we = 1'b1;
               mem_waddr = pick0_ff;
               mem_wdata = '{has_next: 1'b1, link: pick_idx};
               state_in = S_ALLOC2;
            end
         end
         S_ALLOC2: begin
            if (!scan_any) begin
               rsp_load = 1'b1;
               res_status = STATUS_NO_SPACE;
               state_in = S_IDLE;
            end else begin
               pick2_in = pick_idx;
               free_map_in = scan & ~low_vec;
               mem_we = 1'b1;
               mem_waddr = pick1_ff;
               mem_wdata = '{has_next: 1'b1, link: pick_idx};
               state_in = S_LINK;
            end
         end
         S_LINK: begin
            mem_we = 1'b1;
            mem_waddr = pick2_ff;
            mem_wdata = '{has_next: 1'b0, link: '0};
            rsp_load = 1'b1;
            res_status = STATUS_OK;
            res_first = IDX_W'(pick0_ff);
            res_second = IDX_W'(pick1_ff);
            res_third = IDX_W'(pick2_ff);
            state_in = S_IDLE;
         end
         S_WALK: begin
            res_count = count_ff;
            if (!walk_first_ff && !rd_ff.has_next) begin
               rsp_load = 1'b1;
               res_status = STATUS_OK;
               state_in = S_IDLE;
            end else if (!in_range) begin
               rsp_load = 1'b1;
               res_status = STATUS_RANGE;
               state_in = S_IDLE;
            end else if (free_map_ff[cur_idx]) begin
               rsp_load = 1'b1;
               res_status = STATUS_DOUBLE;
               state_in = S_IDLE;
            end else begin
               free_map_in[cur_idx] = 1'b1;
               count_in = count_ff + CNT_W'(1);
               walk_first_in = 1'b0;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         free_map_ff <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         free_map_ff <= free_map_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      avail_ff <= avail_in;
      pick0_ff <= pick0_in;
      pick1_ff <= pick1_in;
      pick2_ff <= pick2_in;
      head_ff <= head_in;
      walk_first_ff <= walk_first_in;
      count_ff <= count_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status;
         rsp_first_ff <= res_first;
         rsp_second_ff <= res_second;
         rsp_third_ff <= res_third;
         rsp_count_ff <= res_count;
      end
   end

   // link memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= link_mem[mem_raddr];
   end

   a_alloc_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_OK && rsp_count_ff == '0) |->
      (rsp_first_ff < rsp_second_ff && rsp_second_ff < rsp_third_ff))
      else $error("allocated chain not in ascending order");

   a_map_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_ALLOC2 && state_ff != S_WALK) |=> $stable(free_map_ff))
      else $error("free map changed outside commit or walk");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_valid_ff) |-> rsp.ready)
      else $error("response overwritten before taken");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_count_ff <= CNT_W'(DESC_COUNT))
      else $error("freed count exceeds table size");

endmodule
